FILE: sv/epmsc_pkg.sv
// Shared types and constants for the encoder PID motor speed controller.
package epmsc_pkg;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int SGAIN_W = 32;
  localparam int TGT_W   = 13;
  localparam int SPD_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DIFF_W  = 18;
  localparam int SUM_W   = 32;
  localparam int DUTY_W  = 8;
  localparam int DIR_W   = 2;

  // Serial multiplier: signed A times signed B, one bit of B per cycle.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 33;
  localparam int ACC_W   = MUL_A_W + MUL_B_W;
  localparam int STEP_W  = $clog2(MUL_B_W);

  localparam logic [1:0] REG_PROP  = 2'd0;
  localparam logic [1:0] REG_INTEG = 2'd1;
  localparam logic [1:0] REG_DERIV = 2'd2;
  localparam logic [1:0] REG_SPEED = 2'd3;

  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
    logic [SGAIN_W-1:0]       speed;
  } gains_t;

  typedef struct packed {
    logic               start;
    logic               clear;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_cmd_t;

endpackage

FILE: sv/epmsc_regs.sv
// Configuration register file behind the APB-style port.
module epmsc_regs import epmsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output gains_t            gains
);

  logic          wr_en;
  logic [1:0]    reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.prop  <= GAIN_W'(256);
      gains.integ <= '0;
      gains.deriv <= '0;
      gains.speed <= SGAIN_W'(65536);
    end else if (wr_en) begin
      case (reg_idx)
        REG_PROP:  gains.prop  <= pwdata[GAIN_W-1:0];
        REG_INTEG: gains.integ <= pwdata[GAIN_W-1:0];
        REG_DERIV: gains.deriv <= pwdata[GAIN_W-1:0];
        REG_SPEED: gains.speed <= pwdata[SGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PROP:  prdata = {{(DATA_W-GAIN_W){gains.prop[GAIN_W-1]}}, gains.prop};
      REG_INTEG: prdata = {{(DATA_W-GAIN_W){gains.integ[GAIN_W-1]}}, gains.integ};
      REG_DERIV: prdata = {{(DATA_W-GAIN_W){gains.deriv[GAIN_W-1]}}, gains.deriv};
      REG_SPEED: prdata = gains.speed;
      default:   prdata = '0;
    endcase
  end

endmodule

FILE: sv/epmsc_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module epmsc_mac import epmsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mac_cmd_t         cmd,
  output logic             done,
  output logic [ACC_W-1:0] acc
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [ACC_W-1:0]  a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [ACC_W-1:0]  addend;
  logic              last;

  assign last   = (step == STEP_W'(MUL_B_W - 1));
  assign addend = b_sh[0] ? a_sh : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The top multiplier bit carries negative weight: subtract on the last step.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_sh <= {{(ACC_W-MUL_A_W){cmd.a[MUL_A_W-1]}}, cmd.a};
      b_sh <= cmd.b;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (busy) begin
      acc  <= last ? (acc - addend) : (acc + addend);
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

FILE: sv/encoder_pid_motor_speed_control.sv
// Encoder-fed PID speed controller for a DC motor: top level and sequencer.
//
// Each request is either an encoder edge (func = 0) or a control tick
// (func = 1). An edge moves the position counter up when enc_b_level is
// high and down when it is low; it gives no result.
// A tick measures speed as the count change since the previous tick times
// the Q16.16 speed_gain (truncated, saturated to 16 bits), forms the error
// against target_rpm, adds it into a saturating 32-bit integral and builds
// u = prop_gain*e + integ_gain*sum + deriv_gain_per_tick*(e - last_error)
// with Q8.8 gains. The result carries pwm_duty = min(|u| >> 8, DUTY_MAX),
// drive_dir (0 stop, 1 forward, 2 reverse, from the sign of u at full
// precision) and speed_rpm. All four products run through one bit-serial
// multiplier that retires one multiplier bit per cycle, so a tick holds
// the block, which takes no other request, from the moment it is accepted
// until its result is loaded; edges are taken one per cycle while the block is idle. A finished
// result sits in the output register, and the next request is accepted
// while it waits.
// Gains are written through the APB-style port at byte offsets 0, 4, 8
// and 12; write them only while the block is idle.
module encoder_pid_motor_speed_control import epmsc_pkg::*; #(
  parameter int COUNT_BITS = 32,
  parameter int DUTY_MAX   = 255
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // request channel
  input  logic                     item_valid,
  output logic                     item_ready,
  input  logic                     func,
  input  logic                     enc_b_level,
  input  logic signed [TGT_W-1:0]  target_rpm,
  // result channel
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [DUTY_W-1:0]        pwm_duty,
  output logic [DIR_W-1:0]         drive_dir,
  output logic signed [SPD_W-1:0]  speed_rpm
);

  localparam int EXT_W   = (COUNT_BITS > 33) ? COUNT_BITS : 33;
  localparam int DUTY_FW = ACC_W - 8;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_SPD   = 4'd2;
  localparam logic [3:0] S_ERR   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_MP    = 4'd5;
  localparam logic [3:0] S_MI    = 4'd6;
  localparam logic [3:0] S_MD    = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  gains_t gains;
  mac_cmd_t mac_cmd;
  logic mac_done;
  logic [ACC_W-1:0] mac_acc;

  logic [3:0] state;
  logic [3:0] state_next;

  logic [COUNT_BITS-1:0] position_count;
  logic [COUNT_BITS-1:0] count_at_last_tick;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] last_error;

  logic [COUNT_BITS-1:0] delta;
  logic signed [TGT_W-1:0] target;
  logic signed [SPD_W-1:0] speed;
  logic signed [ERR_W-1:0] err;
  logic signed [DIFF_W-1:0] diff;
  logic [ACC_W-1:0] umag;
  logic [DIR_W-1:0] dir;

  logic item_take;
  logic out_free;

  assign pready     = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign item_take  = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  epmsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .gains   (gains)
  );

  epmsc_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .done (mac_done),
    .acc  (mac_acc)
  );

  // Magnitude of the count change, clamped to 2^31 before the multiply.
  logic                  delta_neg;
  logic [COUNT_BITS-1:0] mag_full;
  logic [EXT_W-1:0]      mag_ext;
  logic [31:0]           mag32;

  assign delta_neg = delta[COUNT_BITS-1];
  assign mag_full  = delta_neg ? (-delta) : delta;
  assign mag_ext   = EXT_W'(mag_full);
  assign mag32     = (mag_ext > EXT_W'(64'h8000_0000)) ? 32'h8000_0000 : mag_ext[31:0];

  // Speed from the product: q = product >> 16, saturated to 16 bits.
  logic                 q_big;
  logic                 q_top;
  logic [SPD_W-2:0]     q_low;
  logic signed [SPD_W-1:0] speed_calc;

  assign q_big = |mac_acc[ACC_W-1:31];
  assign q_low = mac_acc[30:16];
  assign q_top = q_big || (q_low == {(SPD_W-1){1'b1}});

  always_comb begin
    if (delta_neg) begin
      speed_calc = q_big ? SPD_W'(16'sh8000) : -$signed({1'b0, q_low});
    end else begin
      speed_calc = q_top ? SPD_W'(16'sh7fff) : $signed({1'b0, q_low});
    end
  end

  // Saturating integral update.
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;

  assign sum_wide = {error_sum[SUM_W-1], error_sum} + (SUM_W+1)'(err);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  // Duty clamp on the registered magnitude.
  logic [DUTY_FW-1:0] duty_full;
  logic [DUTY_FW-1:0] duty_clamp;

  assign duty_full  = umag[ACC_W-1:8];
  assign duty_clamp = (duty_full > DUTY_FW'(DUTY_MAX)) ? DUTY_FW'(DUTY_MAX) : duty_full;

  // Multiplier commands: speed, then P, I and D terms into one accumulator.
  always_comb begin
    mac_cmd.start = 1'b0;
    mac_cmd.clear = 1'b0;
    mac_cmd.a     = '0;
    mac_cmd.b     = '0;
    case (state)
      S_DELTA: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {1'b0, mag32};
        mac_cmd.b     = {1'b0, gains.speed};
      end
      S_SUM: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clear = 1'b1;
        mac_cmd.a     = {{(MUL_A_W-ERR_W){err[ERR_W-1]}}, err};
        mac_cmd.b     = {{(MUL_B_W-GAIN_W){gains.prop[GAIN_W-1]}}, gains.prop};
      end
      S_MP: begin
        mac_cmd.start = mac_done;
        mac_cmd.a     = {{(MUL_A_W-SUM_W){error_sum[SUM_W-1]}}, error_sum};
        mac_cmd.b     = {{(MUL_B_W-GAIN_W){gains.integ[GAIN_W-1]}}, gains.integ};
      end
      S_MI: begin
        mac_cmd.start = mac_done;
        mac_cmd.a     = {{(MUL_A_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        mac_cmd.b     = {{(MUL_B_W-GAIN_W){gains.deriv[GAIN_W-1]}}, gains.deriv};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (item_take && func) state_next = S_DELTA;
      S_DELTA: state_next = S_SPD;
      S_SPD:   if (mac_done) state_next = S_ERR;
      S_ERR:   state_next = S_SUM;
      S_SUM:   state_next = S_MP;
      S_MP:    if (mac_done) state_next = S_MI;
      S_MI:    if (mac_done) state_next = S_MD;
      S_MD:    if (mac_done) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state and controller memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      position_count     <= '0;
      count_at_last_tick <= '0;
      error_sum          <= '0;
      last_error         <= '0;
      result_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (item_take && !func) begin
        position_count <= enc_b_level ? (position_count + 1'b1) : (position_count - 1'b1);
      end
      if (item_take && func) begin
        count_at_last_tick <= position_count;
      end
      if (state == S_SUM) begin
        error_sum  <= sum_sat;
        last_error <= err;
      end
      // Load a new result, or drop the old one once it is taken.
      if (state == S_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Tick working values and the output register.
  always_ff @(posedge clk) begin
    if (item_take && func) begin
      delta  <= position_count - count_at_last_tick;
      target <= target_rpm;
    end
    if (state == S_SPD && mac_done) begin
      speed <= speed_calc;
    end
    if (state == S_ERR) begin
      err <= ERR_W'(target) - ERR_W'(speed);
    end
    if (state == S_SUM) begin
      diff <= DIFF_W'(err) - DIFF_W'(last_error);
    end
    if (state == S_MD && mac_done) begin
      umag <= mac_acc[ACC_W-1] ? (-mac_acc) : mac_acc;
      if (mac_acc == '0) begin
        dir <= DIR_STOP;
      end else if (mac_acc[ACC_W-1]) begin
        dir <= DIR_REV;
      end else begin
        dir <= DIR_FWD;
      end
    end
    if (state == S_OUT && out_free) begin
      pwm_duty  <= duty_clamp[DUTY_W-1:0];
      drive_dir <= dir;
      speed_rpm <= speed;
    end
  end

endmodule

FILE: tb/encoder_pid_motor_speed_control_tb.sv
// Self-checking testbench for the encoder PID motor speed controller.
`timescale 1ns / 100ps

module encoder_pid_motor_speed_control_tb;
  import epmsc_pkg::*;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam int DUTY_CAP       = 255;
  localparam int SETTLE_CYCLES  = 160;
  localparam int WATCHDOG_LIMIT = 8000;  // idle cycles before giving up
  localparam int HOLD_CYCLES    = 1500;  // long receiver hold-off
  localparam int PRESSURE_AT    = 20;    // result count that triggers it

  typedef struct packed {
    logic                    func;
    logic                    enc_b;
    logic signed [TGT_W-1:0] target;
  } motor_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic [DIR_W-1:0]        dir;
    logic signed [SPD_W-1:0] speed;
  } drive_out_t;

  // Clock and block ports; every input starts at a known value.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  logic                    item_valid = 1'b0;
  logic                    item_ready;
  logic                    func = 1'b0;
  logic                    enc_b_level = 1'b0;
  logic signed [TGT_W-1:0] target_rpm = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic [DUTY_W-1:0]       pwm_duty;
  logic [DIR_W-1:0]        drive_dir;
  logic signed [SPD_W-1:0] speed_rpm;

  encoder_pid_motor_speed_control dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .func         (func),
    .enc_b_level  (enc_b_level),
    .target_rpm   (target_rpm),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pwm_duty     (pwm_duty),
    .drive_dir    (drive_dir),
    .speed_rpm    (speed_rpm)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Controller model: gains and state, reset values as after rst.
  logic signed [GAIN_W-1:0] gain_p = 16'sd256;
  logic signed [GAIN_W-1:0] gain_i = '0;
  logic signed [GAIN_W-1:0] gain_d = '0;
  logic [SGAIN_W-1:0]       gain_speed = 32'h0001_0000;
  logic [31:0]              pos_count = '0;
  logic [31:0]              tick_count = '0;
  logic signed [SUM_W-1:0]  err_sum = '0;
  logic signed [ERR_W-1:0]  prev_err = '0;

  motor_req_t req_q[$];           // requests waiting for the driver
  drive_out_t expected_drive[$];  // predicted results, oldest first

  int  items_queued = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  logic item_taken = 1'b0;

  // Move the position counter by one encoder edge; wraps at 32 bits.
  function automatic void step_position(input logic up);
    if (up) pos_count = pos_count + 32'd1;
    else pos_count = pos_count - 32'd1;
  endfunction

  // Run one control tick on the model and return the drive it produces.
  function automatic drive_out_t control_tick(input logic signed [TGT_W-1:0] tgt);
    logic [31:0] delta;
    logic [31:0] dmag;
    logic [63:0] prod;
    longint      spd, err, acc, u, umag, duty;
    drive_out_t  r;
    delta      = pos_count - tick_count;
    tick_count = pos_count;
    dmag       = delta[31] ? -delta : delta;
    prod       = ({32'd0, dmag} * {32'd0, gain_speed}) >> 16;
    // Truncate toward zero, then saturate to 16 bits.
    if (delta[31]) spd = (prod >= 64'd32768) ? -32768 : -longint'(prod);
    else spd = (prod >= 64'd32767) ? 32767 : longint'(prod);
    err = longint'(tgt) - spd;
    acc = longint'(err_sum) + err;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    err_sum = acc[31:0];
    u = longint'(gain_p) * err + longint'(gain_i) * longint'(err_sum)
      + longint'(gain_d) * (err - longint'(prev_err));
    prev_err = err[ERR_W-1:0];
    // Direction follows u at full precision, so a fraction still drives.
    if (u > 0) begin
      r.dir = DIR_FWD;
      umag  = u;
    end else if (u < 0) begin
      r.dir = DIR_REV;
      umag  = -u;
    end else begin
      r.dir = DIR_STOP;
      umag  = 0;
    end
    duty = umag >>> 8;
    if (duty > DUTY_CAP) duty = DUTY_CAP;
    r.duty  = duty[DUTY_W-1:0];
    r.speed = spd[SPD_W-1:0];
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request driver: hold each request until taken, then advance.
  int   send_gap = 0;
  logic send_steady = 1'b0;
  motor_req_t cur_req = '0;

  always @(negedge clk) begin
    logic nxt_valid;
    if (!rst && (!item_valid || item_taken)) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (req_q.size() > 0) begin
        cur_req   = req_q.pop_front();
        nxt_valid = 1'b1;
        if (!send_steady && $urandom_range(0, 99) >= 45) send_gap = pick_gap();
        if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
      end
      item_valid  <= nxt_valid;
      func        <= cur_req.func;
      enc_b_level <= cur_req.enc_b;
      target_rpm  <= cur_req.target;
    end
  end

  // Result receiver: random stalls, steady stretches, one long hold-off.
  int   recv_stall = 0;
  logic recv_steady = 1'b0;
  logic pressure_done = 1'b0;

  always @(negedge clk) begin
    logic nxt_ready;
    if (!rst) begin
      nxt_ready = 1'b1;
      if (!pressure_done && results_seen >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        recv_stall    = HOLD_CYCLES;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        nxt_ready = 1'b0;
      end else if (!recv_steady && $urandom_range(0, 3) == 0) begin
        recv_stall = pick_gap() - 1;
        nxt_ready  = 1'b0;
      end
      if ($urandom_range(0, 99) == 0) recv_steady = !recv_steady;
      result_ready <= nxt_ready;
    end
  end

  task automatic report(input string field, input int want, input int got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Monitor: update the model on every accepted request or register write,
  // check every accepted result, and watch for a hang.
  always @(posedge clk) begin
    drive_out_t want;
    logic       cfg_fire;
    logic       res_fire;
    if (!rst) begin
      item_taken = item_valid && item_ready;
      cfg_fire   = psel && penable && pwrite && pready;
      res_fire   = result_valid && result_ready;
      if (item_taken) begin
        items_taken++;
        if (func == FUNC_TICK) expected_drive.push_back(control_tick(target_rpm));
        else step_position(enc_b_level);
      end
      if (cfg_fire) begin
        case (paddr[3:2])
          REG_PROP:  gain_p = pwdata[GAIN_W-1:0];
          REG_INTEG: gain_i = pwdata[GAIN_W-1:0];
          REG_DERIV: gain_d = pwdata[GAIN_W-1:0];
          REG_SPEED: gain_speed = pwdata[SGAIN_W-1:0];
          default: ;
        endcase
      end
      if (res_fire) begin
        results_seen++;
        if (expected_drive.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, actual duty %0d dir %0d speed %0d",
                   $time, pwm_duty, drive_dir, speed_rpm);
        end else begin
          want = expected_drive.pop_front();
          if (pwm_duty !== want.duty) report("pwm_duty", want.duty, pwm_duty);
          if (drive_dir !== want.dir) report("drive_dir", want.dir, drive_dir);
          if (speed_rpm !== want.speed) report("speed_rpm", want.speed, speed_rpm);
        end
      end
      if (item_taken || cfg_fire || res_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic push_req(input logic f, input logic b, input int t);
    motor_req_t r;
    r.func   = f;
    r.enc_b  = b;
    r.target = TGT_W'(t);
    req_q.push_back(r);
    items_queued++;
  endtask

  // Write one gain register: setup cycle, then access until pready.
  task automatic write_gain(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_gains(input int p, input int i, input int d, input logic [31:0] s);
    write_gain(REG_PROP, p);
    write_gain(REG_INTEG, i);
    write_gain(REG_DERIV, d);
    write_gain(REG_SPEED, s);
  endtask

  // Let every request drain and every expected result arrive, then wait out the settle time.
  task automatic wait_drained();
    while (items_taken != items_queued || expected_drive.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_gain(input int span);
    logic signed [GAIN_W-1:0] g;
    if ($urandom_range(0, 3) != 0) g = GAIN_W'($urandom_range(0, 2 * span) - span);
    else g = GAIN_W'($urandom);
    return int'(g);
  endfunction

  function automatic int pick_target();
    if ($urandom_range(0, 9) < 6) return int'($urandom_range(0, 800)) - 400;
    return $urandom;
  endfunction

  // Random gains: mostly speed gains that keep rpm in range, some wild ones.
  task automatic random_gains();
    logic [31:0] s;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) s = $urandom_range(0, 32'h0010_0000);
    else if (pick < 9) s = $urandom;
    else s = 32'hFFFF_FFFF;
    set_gains(pick_gain(1024), pick_gain(32), pick_gain(256), s);
  endtask

  // Runs of edges mostly one way with stray reversals, ticks in between.
  task automatic random_phase(input int n);
    int   k, tick_pct;
    logic up;
    tick_pct = $urandom_range(4, 20);
    up       = 1'($urandom_range(0, 1));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < tick_pct) begin
        push_req(FUNC_TICK, 1'($urandom_range(0, 1)), pick_target());
      end else begin
        if ($urandom_range(0, 39) == 0) up = !up;
        push_req(FUNC_EDGE, ($urandom_range(0, 9) == 0) ? !up : up, $urandom);
      end
    end
  endtask

  initial begin
    int ph;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains: idle tick, clamped duty both ways, small forward drive.
    push_req(FUNC_TICK, 1'b0, 0);
    push_req(FUNC_EDGE, 1'b1, -4096);
    push_req(FUNC_EDGE, 1'b1, 4095);
    push_req(FUNC_EDGE, 1'b1, $urandom);
    push_req(FUNC_EDGE, 1'b0, 0);
    push_req(FUNC_TICK, 1'b0, 4095);
    push_req(FUNC_TICK, 1'b1, -4096);
    push_req(FUNC_EDGE, 1'b0, 1);
    push_req(FUNC_EDGE, 1'b0, -1);
    push_req(FUNC_TICK, 1'b1, 0);
    wait_drained();

    // Unit gain on a huge speed gain: fractional drive, saturated speed.
    set_gains(1, 0, 0, 32'hFFFF_FFFF);
    push_req(FUNC_TICK, 1'b0, 5);
    push_req(FUNC_TICK, 1'b1, -3);
    push_req(FUNC_EDGE, 1'b1, 0);
    push_req(FUNC_TICK, 1'b0, 0);
    push_req(FUNC_EDGE, 1'b0, 0);
    push_req(FUNC_TICK, 1'b0, 4095);
    wait_drained();

    // Gain extremes, one sign pattern and then the other.
    set_gains(-32768, 32767, -32768, 32'h0000_0000);
    push_req(FUNC_EDGE, 1'b1, 0);
    push_req(FUNC_TICK, 1'b0, -4096);
    push_req(FUNC_TICK, 1'b1, 4095);
    wait_drained();
    set_gains(32767, -32768, 32767, 32'h0000_8000);
    push_req(FUNC_EDGE, 1'b0, 0);
    push_req(FUNC_EDGE, 1'b0, 0);
    push_req(FUNC_TICK, 1'b0, 4095);
    push_req(FUNC_TICK, 1'b1, -1);
    wait_drained();

    // Random phases, each with fresh gains written while idle.
    for (ph = 0; ph < 8; ph++) begin
      random_gains();
      random_phase(235);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/epmsc_pkg.sv
sv/epmsc_regs.sv
sv/epmsc_mac.sv
sv/encoder_pid_motor_speed_control.sv
tb/encoder_pid_motor_speed_control_tb.sv
